// File: design/ps2mct_pkg.sv
// Package for the PS/2 mouse packet cursor tracker: widths, bit positions and state codes.
`timescale 1ns / 1ps

package ps2mct_pkg;

    // Cursor coordinate width and register widths
    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = 13;
    localparam int BYTE_BITS  = 8;
    localparam int DELTA_BITS = BYTE_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int CMP_BITS   = (SIZE_BITS > COORD_BITS + 1) ? SIZE_BITS : COORD_BITS + 1;

    // Reset screen size
    localparam logic [SIZE_BITS-1:0] SCREEN_W_RESET = SIZE_BITS'(1024);
    localparam logic [SIZE_BITS-1:0] SCREEN_H_RESET = SIZE_BITS'(768);

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_W = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_H = 1'b1;

    // Bit positions in the first packet byte
    localparam int SYNC_POS  = 3;
    localparam int LEFT_POS  = 0;
    localparam int RIGHT_POS = 1;

    // Packet byte sequencer
    typedef enum logic [2:0] {
        PH_FIRST = 3'b001,
        PH_DX    = 3'b010,
        PH_DY    = 3'b100
    } phase_t;

endpackage

// File: design/ps2mct_clamp.sv
// Coordinate update: adds a signed delta to a position and clamps it to the screen size.
`timescale 1ns / 1ps

module ps2mct_clamp
(
    input  logic [ps2mct_pkg::COORD_BITS-1:0]        pos,
    input  logic signed [ps2mct_pkg::DELTA_BITS-1:0] delta,
    input  logic [ps2mct_pkg::SIZE_BITS-1:0]         size,
    output logic [ps2mct_pkg::COORD_BITS-1:0]        result
);
    import ps2mct_pkg::*;

    logic [COORD_BITS-1:0]      lim;
    logic [CMP_BITS-1:0]        size_ext;
    logic signed [SUM_BITS-1:0] sum;
    logic [SUM_BITS-2:0]        sum_mag;

    // Largest legal coordinate: size zero acts as one, large sizes saturate
    assign size_ext = CMP_BITS'(size);

    always_comb
    begin
        if (size == '0)
        begin
            lim = '0;
        end
        else if (size_ext > (CMP_BITS'(1) << COORD_BITS))
        begin
            lim = '1;
        end
        else
        begin
            lim = COORD_BITS'(size - SIZE_BITS'(1));
        end
    end

    // Signed sum, then clamp to 0..lim
    assign sum     = $signed({2'b00, pos}) + SUM_BITS'(delta);
    assign sum_mag = sum[SUM_BITS-2:0];

    always_comb
    begin
        if (sum[SUM_BITS-1])
        begin
            result = '0;
        end
        else if (sum_mag > (SUM_BITS-1)'(lim))
        begin
            result = lim;
        end
        else
        begin
            result = sum_mag[COORD_BITS-1:0];
        end
    end

endmodule

// File: design/ps2_mouse_packet_cursor_tracker_top.sv
// Top level of the PS/2 mouse packet cursor tracker.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  in      | input     | in_valid/in_stall  | from_aux, data_byte
//  out     | output    | out_valid/out_stall| cursor_x, cursor_y, left_btn, right_btn
//  cfg     | input     | cfg_we             | cfg_index, cfg_data (screen width / height)
//
// One byte is taken per cycle while in_stall is low; a byte sits in the input register and
// is processed by the sequencer and clamp logic when the packet stage advances, so a third
// byte passes through the input register before it loads the result register. The stage
// between is one 14-bit add and compare per coordinate.
// Reset clears the sequencer, cursor position and valid flags, and loads 1024 x 768.
// A stalled result holds the packet stage; the input register then fills and in_stall rises.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  from_aux,
    input  logic [7:0]                            data_byte,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ps2mct_pkg::COORD_BITS-1:0]     cursor_x,
    output logic [ps2mct_pkg::COORD_BITS-1:0]     cursor_y,
    output logic                                  left_btn,
    output logic                                  right_btn,
    input  logic                                  cfg_we,
    input  logic [ps2mct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ps2mct_pkg::SIZE_BITS-1:0]      cfg_data
);
    import ps2mct_pkg::*;

    logic [SIZE_BITS-1:0]  screen_w_reg;
    logic [SIZE_BITS-1:0]  screen_h_reg;

    logic                  in_valid_reg;
    logic                  aux_reg;
    logic [BYTE_BITS-1:0]  byte_reg;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [1:0]            buttons_reg;
    logic [BYTE_BITS-1:0]  dx_reg;
    logic [COORD_BITS-1:0] pos_x_reg;
    logic [COORD_BITS-1:0] pos_y_reg;
    logic [COORD_BITS-1:0] pos_x_next;
    logic [COORD_BITS-1:0] pos_y_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  in_take;
    logic                  advance;
    logic                  aux_item;
    logic                  first_ok;
    logic                  finish;
    logic signed [DELTA_BITS-1:0] dx_ext;
    logic signed [DELTA_BITS-1:0] dy_neg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_w_reg <= SCREEN_W_RESET;
            screen_h_reg <= SCREEN_H_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_W: screen_w_reg <= cfg_data;
                CFG_SCREEN_H: screen_h_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Handshake: the packet stage moves when the result register can take a result
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            aux_reg  <= from_aux;
            byte_reg <= data_byte;
        end
    end

    // Packet sequencer decode
    assign aux_item = advance && aux_reg;
    assign first_ok = aux_item && (phase_reg == PH_FIRST) && byte_reg[SYNC_POS];
    assign finish   = aux_item && (phase_reg == PH_DY);

    always_comb
    begin
        phase_next = phase_reg;
        if (aux_item)
        begin
            case (phase_reg)
                PH_FIRST: phase_next = byte_reg[SYNC_POS] ? PH_DX : PH_FIRST;
                PH_DX:    phase_next = PH_DY;
                PH_DY:    phase_next = PH_FIRST;
                default:  phase_next = PH_FIRST;
            endcase
        end
    end

    // Deltas: X sign-extended, Y negated (screen rows grow downwards)
    assign dx_ext = $signed({dx_reg[BYTE_BITS-1], dx_reg});
    assign dy_neg = DELTA_BITS'(0) - $signed({byte_reg[BYTE_BITS-1], byte_reg});

    ps2mct_clamp u_clamp_x
    (
        .pos    (pos_x_reg),
        .delta  (dx_ext),
        .size   (screen_w_reg),
        .result (pos_x_next)
    );

    ps2mct_clamp u_clamp_y
    (
        .pos    (pos_y_reg),
        .delta  (dy_neg),
        .size   (screen_h_reg),
        .result (pos_y_next)
    );

    // Result valid: set on a finished packet, cleared once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and cursor position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
        end
    end

    // Packet bytes held between phases
    always_ff @(posedge clk)
    begin
        if (first_ok)
        begin
            buttons_reg <= byte_reg[1:0];
        end
        if (aux_item && (phase_reg == PH_DX))
        begin
            dx_reg <= byte_reg;
        end
    end

    // Outputs: position only changes when a new result is loaded; buttons follow a first byte
    assign out_valid = out_valid_reg;
    assign cursor_x  = pos_x_reg;
    assign cursor_y  = pos_y_reg;
    assign left_btn  = buttons_reg[LEFT_POS];
    assign right_btn = buttons_reg[RIGHT_POS];

`ifndef SYNTHESIS
    // A finished packet always produces a result on the next edge
    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> out_valid_reg)
        else $error("finished packet did not load a result");

    // A new result only appears after a third packet byte
    a_result_from_packet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && aux_reg && (phase_reg == PH_DY)))
        else $error("result raised without a completed packet");

    // The first byte of a packet may not move on without the sync bit
    a_sync_needed: assert property (@(posedge clk) disable iff (!rst_n)
        (aux_item && (phase_reg == PH_FIRST) && !byte_reg[SYNC_POS]) |=> (phase_reg == PH_FIRST))
        else $error("unsynchronised first byte advanced the sequencer");
`endif

endmodule

// File: dv/ps2_mouse_packet_cursor_tracker_checker.sv
// Checker for the PS/2 mouse packet cursor tracker: follows the cursor and compares every report.
`timescale 1ns / 1ps

module ps2_mouse_packet_cursor_tracker_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic                                  from_aux,
    input  logic [7:0]                            data_byte,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic [ps2mct_pkg::COORD_BITS-1:0]     cursor_x,
    input  logic [ps2mct_pkg::COORD_BITS-1:0]     cursor_y,
    input  logic                                  left_btn,
    input  logic                                  right_btn,
    input  logic                                  cfg_we,
    input  logic [ps2mct_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ps2mct_pkg::SIZE_BITS-1:0]      cfg_data,
    output int                                    fail_count,
    output int                                    reports_pending
);

    import ps2mct_pkg::*;

    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
    } cursor_report_t;

    cursor_report_t        cursor_reports[$];
    cursor_report_t        oldest;
    int                    mismatches = 0;
    int                    waiting    = 0;

    // Own copy of the registers and the packet assembly state
    logic [SIZE_BITS-1:0]  width_reg;
    logic [SIZE_BITS-1:0]  height_reg;
    phase_t                next_byte;
    logic [1:0]            held_buttons;
    logic [BYTE_BITS-1:0]  held_dx;
    logic [COORD_BITS-1:0] track_x;
    logic [COORD_BITS-1:0] track_y;

    assign fail_count      = mismatches;
    assign reports_pending = waiting;

    // Extent really used for clamping: zero acts as one, oversize saturates to the full range
    function automatic int clamp_extent(logic [SIZE_BITS-1:0] size);
        int n;
        n = int'(size);
        if (n == 0)
            n = 1;
        if (n > (1 << COORD_BITS))
            n = 1 << COORD_BITS;
        return n;
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(int v, int extent);
        if (v < 0)
            return '0;
        if (v >= extent)
            return COORD_BITS'(extent - 1);
        return COORD_BITS'(v);
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t: cursor tracker mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // One mouse byte through the packet sequencer; the third byte yields a report
    task automatic take_mouse_byte(logic [BYTE_BITS-1:0] b);
        cursor_report_t r;
        int             nx;
        int             ny;
        case (next_byte)
            PH_DX:
            begin
                held_dx   = b;
                next_byte = PH_DY;
            end
            PH_DY:
            begin
                nx      = int'(track_x) + int'($signed(held_dx));
                ny      = int'(track_y) - int'($signed(b));
                track_x = clamp_coord(nx, clamp_extent(width_reg));
                track_y = clamp_coord(ny, clamp_extent(height_reg));
                r.x     = track_x;
                r.y     = track_y;
                r.left  = held_buttons[LEFT_POS];
                r.right = held_buttons[RIGHT_POS];
                cursor_reports.push_back(r);
                next_byte = PH_FIRST;
            end
            default:
                // a first byte without the sync bit is dropped
                if (b[SYNC_POS])
                begin
                    held_buttons = b[1:0];
                    next_byte    = PH_DX;
                end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    = SCREEN_W_RESET;
            height_reg   = SCREEN_H_RESET;
            next_byte    = PH_FIRST;
            held_buttons = '0;
            held_dx      = '0;
            track_x      = '0;
            track_y      = '0;
            cursor_reports.delete();
        end
        else
        begin
            // results first: a byte taken at this edge cannot have reached the output yet
            if (out_valid && !out_stall)
            begin
                if (cursor_reports.size() == 0)
                    report_mismatch("report with nothing expected");
                else
                begin
                    oldest = cursor_reports.pop_front();
                    if (cursor_x !== oldest.x)
                        report_mismatch($sformatf("cursor_x %0d, expected %0d",
                                                  cursor_x, oldest.x));
                    if (cursor_y !== oldest.y)
                        report_mismatch($sformatf("cursor_y %0d, expected %0d",
                                                  cursor_y, oldest.y));
                    if (left_btn !== oldest.left)
                        report_mismatch($sformatf("left_btn %b, expected %b",
                                                  left_btn, oldest.left));
                    if (right_btn !== oldest.right)
                        report_mismatch($sformatf("right_btn %b, expected %b",
                                                  right_btn, oldest.right));
                end
            end

            // bytes from the keyboard side are ignored
            if (in_valid && !in_stall && from_aux)
                take_mouse_byte(data_byte);

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SCREEN_W: width_reg  = cfg_data;
                    CFG_SCREEN_H: height_reg = cfg_data;
                    default:      ;
                endcase
            end
        end
        waiting = cursor_reports.size();
    end

endmodule

// File: dv/tb_ps2_mouse_packet_cursor_tracker_top.sv
// Testbench top for the PS/2 mouse packet cursor tracker: clock, reset, byte stream and verdict.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_cursor_tracker_top;

    import ps2mct_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 88;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic                      from_aux;
    logic [7:0]                data_byte;
    logic                      out_valid;
    logic                      out_stall;
    logic [COORD_BITS-1:0]     cursor_x;
    logic [COORD_BITS-1:0]     cursor_y;
    logic                      left_btn;
    logic                      right_btn;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [SIZE_BITS-1:0]      cfg_data;

    int fail_count;
    int reports_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    logic drift_right  = 1'b1;
    logic drift_down   = 1'b1;

    // Screen sizes per phase, extremes and out-of-range register values included
    int phase_w[PHASES] = '{1, 4096, 0, 8191, 640, 2, 1024, 4096};
    int phase_h[PHASES] = '{1, 4096, 8191, 0, 480, 4096, 768, 3};

    ps2_mouse_packet_cursor_tracker_top DUT (.*);

    ps2_mouse_packet_cursor_tracker_checker u_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_stall = ($urandom_range(0, 99) < recv_stall_pct);

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the byte is taken
    task automatic send_byte(logic aux, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        from_aux  = aux;
        data_byte = b;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_packet(logic [7:0] first, logic [7:0] dx, logic [7:0] dy);
        send_byte(1'b1, first);
        send_byte(1'b1, dx);
        send_byte(1'b1, dy);
    endtask

    // Hold the sender until every report is in, then let the pipeline empty
    task automatic drain;
        in_valid = 1'b0;
        wait (reports_pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_size(logic [CFG_INDEX_BITS-1:0] idx, int value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = SIZE_BITS'(value);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Delta biased to the largest step in the current drift direction
    function automatic logic [7:0] pick_delta(logic up);
        if ($urandom_range(0, 99) < 40)
            return up ? 8'h7F : 8'h80;
        return 8'($urandom);
    endfunction

    // Mostly well-formed packets, with keyboard bytes and stray mouse bytes mixed in
    task automatic run_random(int mouse_bytes);
        int         sent;
        int         pick;
        logic [7:0] first;
        sent = 0;
        while (sent < mouse_bytes)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0)
                drift_right = ~drift_right;
            if ($urandom_range(0, 19) == 0)
                drift_down = ~drift_down;
            if (pick < 8)
                send_byte(1'b0, 8'($urandom));
            else if (pick < 16)
            begin
                send_byte(1'b1, 8'($urandom));
                sent++;
            end
            else
            begin
                first           = 8'($urandom);
                first[SYNC_POS] = 1'b1;
                send_packet(first, pick_delta(drift_right), pick_delta(!drift_down));
                sent += 3;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        from_aux  = 1'b0;
        data_byte = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SCREEN_W;
        cfg_data  = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: ignored keyboard byte, dropped first byte, delta extremes, interleaving
        send_byte(1'b0, 8'hFF);
        send_byte(1'b1, 8'h00);
        send_packet(8'h0B, 8'h7F, 8'h80);
        send_packet(8'h08, 8'h80, 8'h7F);
        send_byte(1'b1, 8'h09);
        send_byte(1'b0, 8'h55);
        send_byte(1'b1, 8'h01);
        send_byte(1'b1, 8'hFF);
        send_packet(8'hFF, 8'hFF, 8'h00);
        send_packet(8'h0A, 8'h00, 8'h00);
        send_packet(8'hF7, 8'h80, 8'h80);
        drain();

        // Random phases over several screen sizes and idle patterns
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 6)
            begin
                phase_w[p] = $urandom_range(1, 4096);
                phase_h[p] = $urandom_range(1, 4096);
            end
            write_size(CFG_SCREEN_W, phase_w[p]);
            write_size(CFG_SCREEN_H, phase_h[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            run_random(PHASE_BYTES / 2);
            drain();
            run_random(PHASE_BYTES / 2);
            drain();
        end

        recv_stall_pct = 0;
        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
